@@ design/tfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// tfsa_pkg: shared types and constants of the frame slot allocator
// Pool geometry, status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tfsa_pkg;

  // Pool geometry. The busy map is kept as ROWS words of ROW_BITS bits each.
  localparam int SLOTS    = 1024;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int COUNT_W  = $clog2(SLOTS + 1);
  localparam int ROW_BITS = 32;
  localparam int COL_W    = $clog2(ROW_BITS);
  localparam int ROWS     = SLOTS / ROW_BITS;
  localparam int ROW_W    = $clog2(ROWS);

  typedef enum logic [1:0] {
    StGranted  = 2'd0,
    StFull     = 2'd1,
    StReleased = 2'd2,
    StIgnored  = 2'd3
  } status_e;

  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CtlIdle,
    CtlReadA,
    CtlEvalA,
    CtlReadB,
    CtlEvalB,
    CtlReply
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read_a;
    logic eval_a;
    logic read_b;
    logic eval_b;
  } tfsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pool_full;
    logic hit_a;
    logic is_put;
  } tfsa_sts_t;

  // Index of the lowest set bit of a busy map word.
  function automatic logic [COL_W-1:0] first_col(input logic [ROW_BITS-1:0] v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = COL_W'(i);
      end
    end
    return idx;
  endfunction

  // Index of the lowest set bit of a row summary vector.
  function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ROW_W'(i);
      end
    end
    return idx;
  endfunction

  // Rotate a row summary so that element base lands at position zero.
  function automatic logic [ROWS-1:0] rotate_rows(input logic [ROWS-1:0] v,
                                                  input logic [ROW_W-1:0] base);
    logic [ROWS-1:0] r;
    for (int i = 0; i < ROWS; i++) begin
      r[i] = v[ROW_W'(base + ROW_W'(i))];
    end
    return r;
  endfunction

endpackage

@@ design/tfsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfsa_ctrl: request sequencer of the frame slot allocator
// Steps each request through the busy map reads and evaluations and raises
// the result strobe for one cycle at the end.
// ----------------------------------------------------------------------------
module tfsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tfsa_pkg::tfsa_sts_t sts_i,
  output tfsa_pkg::tfsa_cmd_t cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import tfsa_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtlIdle: begin
        if (start_i) begin
          state_d = CtlReadA;
        end
      end
      CtlReadA: begin
        // A get against a full pool needs no search at all.
        state_d = sts_i.pool_full ? CtlReply : CtlEvalA;
      end
      CtlEvalA: begin
        state_d = (sts_i.is_put || sts_i.hit_a) ? CtlReply : CtlReadB;
      end
      CtlReadB: state_d = CtlEvalB;
      CtlEvalB: state_d = CtlReply;
      CtlReply: state_d = CtlIdle;
      default:  state_d = CtlIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      CtlIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      CtlReadA: cmd_o.read_a = 1'b1;
      CtlEvalA: cmd_o.eval_a = 1'b1;
      CtlReadB: cmd_o.read_b = 1'b1;
      CtlEvalB: cmd_o.eval_b = 1'b1;
      CtlReply: done_o       = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ design/tfsa_dp.sv @@
// ----------------------------------------------------------------------------
// tfsa_dp: busy map, row summary and counters of the frame slot allocator
// Holds the busy map as a word memory with per-row valid bits, a per-row
// full summary for the circular search, the next pointer and the count.
// ----------------------------------------------------------------------------
module tfsa_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfsa_pkg::tfsa_cmd_t             cmd_i,
  input  logic                            opcode_i,
  input  logic [tfsa_pkg::SLOT_W-1:0]     slot_to_release_i,
  output tfsa_pkg::tfsa_sts_t             sts_o,
  output logic [1:0]                      status_o,
  output logic [tfsa_pkg::SLOT_W-1:0]     granted_slot_o,
  output logic [tfsa_pkg::COUNT_W-1:0]    slots_in_use_o
);
  import tfsa_pkg::*;

  logic [ROW_BITS-1:0] mem_q [ROWS];
  logic [ROWS-1:0]     row_valid_q;
  logic [ROWS-1:0]     row_full_q;

  logic                op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   search_q;
  logic [COUNT_W-1:0]  count_q;
  logic [ROW_W-1:0]    row_q;
  logic [ROW_W-1:0]    row_b_q;
  logic [ROW_BITS-1:0] rdata_q;
  logic                rvalid_q;
  status_e             res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;

  logic [ROW_W-1:0]    raddr;
  logic [ROW_BITS-1:0] row_word;
  logic [COL_W-1:0]    col;
  logic [ROW_BITS-1:0] free_a;
  logic                hit_a;
  logic [COL_W-1:0]    pick_col;
  logic [ROW_BITS-1:0] wdata;
  logic                commit;
  logic                pool_full;
  logic [ROW_W-1:0]    next_row_base;
  logic [ROWS-1:0]     rot_open;

  assign pool_full = (op_q == OpGet) && (count_q == COUNT_W'(SLOTS));
  assign raddr     = cmd_i.read_b ? row_b_q :
                     (op_q == OpPut) ? slot_q[SLOT_W-1:COL_W] : search_q[SLOT_W-1:COL_W];

  // A row never written since reset reads as all free.
  assign row_word = rvalid_q ? rdata_q : '0;
  assign col      = (op_q == OpPut) ? slot_q[COL_W-1:0] : search_q[COL_W-1:0];
  assign free_a   = ~row_word & ({ROW_BITS{1'b1}} << col);
  assign hit_a    = (op_q == OpPut) ? row_word[col] : (|free_a);
  assign pick_col = cmd_i.eval_b ? first_col(~row_word) : first_col(free_a);

  always_comb begin
    if (op_q == OpPut) begin
      wdata = row_word & ~(ROW_BITS'(1) << col);
    end else begin
      wdata = row_word | (ROW_BITS'(1) << pick_col);
    end
  end

  assign commit = (cmd_i.eval_a && hit_a) || cmd_i.eval_b;

  // Circular row search starts one row past the start row and wraps back to it.
  assign next_row_base = ROW_W'(search_q[SLOT_W-1:COL_W] + ROW_W'(1));
  assign rot_open      = rotate_rows(~row_full_q, next_row_base);

  assign sts_o.pool_full = pool_full;
  assign sts_o.hit_a     = hit_a;
  assign sts_o.is_put    = (op_q == OpPut);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_a || cmd_i.read_b) begin
      rdata_q <= mem_q[raddr];
    end
    if (commit) begin
      mem_q[row_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      slot_q <= slot_to_release_i;
    end
    if (cmd_i.read_a || cmd_i.read_b) begin
      row_q <= raddr;
    end
    if (cmd_i.eval_a) begin
      row_b_q <= ROW_W'(next_row_base + first_row(rot_open));
    end
    if (cmd_i.read_a && pool_full) begin
      res_status_q <= StFull;
      res_slot_q   <= '0;
    end
    if (cmd_i.eval_a) begin
      if (op_q == OpPut) begin
        res_status_q <= hit_a ? StReleased : StIgnored;
        res_slot_q   <= '0;
      end else if (hit_a) begin
        res_status_q <= StGranted;
        res_slot_q   <= {row_q, pick_col};
      end
    end
    if (cmd_i.eval_b) begin
      res_status_q <= StGranted;
      res_slot_q   <= {row_q, pick_col};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      row_full_q  <= '0;
      rvalid_q    <= 1'b0;
      search_q    <= '0;
      count_q     <= '0;
    end else begin
      if (cmd_i.read_a || cmd_i.read_b) begin
        rvalid_q <= row_valid_q[raddr];
      end
      if (commit) begin
        row_valid_q[row_q] <= 1'b1;
        row_full_q[row_q]  <= &wdata;
        if (op_q == OpPut) begin
          if (count_q != '0) begin
            count_q <= count_q - COUNT_W'(1);
          end
        end else begin
          count_q  <= count_q + COUNT_W'(1);
          search_q <= SLOT_W'({row_q, pick_col} + SLOT_W'(1));
        end
      end
    end
  end

  assign status_o       = res_status_q;
  assign granted_slot_o = res_slot_q;
  assign slots_in_use_o = count_q;

  // The held count can never pass the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(SLOTS))
    else $error("held count exceeds pool size");

  // The second row read is taken only when a free slot is known to exist there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval_b |-> !row_full_q[row_q])
    else $error("second search row holds no free slot");

  // After a second-row grant the next pointer sits just past the granted slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval_b |=> (res_status_q == StGranted) &&
                     (search_q == SLOT_W'(res_slot_q + SLOT_W'(1))))
    else $error("next pointer does not follow granted slot");

endmodule

@@ design/tx_frame_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// tx_frame_slot_allocator_core: next-fit allocator for transmit frame slots
// Top level joining the request sequencer and the busy map datapath.
// ----------------------------------------------------------------------------
// Usage: the caller raises start_i with opcode_i and slot_to_release_i; the
// item is taken at the clock edge where start_i is high and busy_o is low.
// Opcode zero claims a free slot, searching circularly from the next pointer;
// opcode one gives back the named slot. Every item produces exactly one result
// on status_o, granted_slot_o and slots_in_use_o, shown for a single cycle
// while done_o is high. The receiver cannot stall, so the result is taken at
// the edge that ends that cycle; the outputs are not cleared afterward.
// Sequence per item: a get against a full pool goes from the first read to
// the result state; a put, or a get whose free slot lies in the row of the
// next pointer, reads and evaluates that row and then replies; a get that has
// to move to another row reads and evaluates a second row too. The extra read
// of the busy map memory (one registered read per row) sets the longer case;
// its row comes from a per-row full summary in one step, never a slot scan.
// Reset clears the per-row valid and full bits, the next pointer and the held
// count at once, so the block takes its first item right after reset.
// ----------------------------------------------------------------------------
module tx_frame_slot_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         opcode_i,
  input  logic [tfsa_pkg::SLOT_W-1:0]  slot_to_release_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [tfsa_pkg::SLOT_W-1:0]  granted_slot_o,
  output logic [tfsa_pkg::COUNT_W-1:0] slots_in_use_o
);
  import tfsa_pkg::*;

  tfsa_cmd_t cmd;
  tfsa_sts_t sts;

  // The sequencer owns the handshake and the timing of each item.
  tfsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // The datapath holds all allocator state and the result registers, which
  // stay stable from the step that writes them through the result cycle.
  tfsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (opcode_i),
    .slot_to_release_i (slot_to_release_i),
    .sts_o             (sts),
    .status_o          (status_o),
    .granted_slot_o    (granted_slot_o),
    .slots_in_use_o    (slots_in_use_o)
  );

endmodule
